// ===== rtl/core/quaternion_nlerp_unit_macros.svh =====
// Assertion macros for the quaternion blend pipeline.
// Used by quaternion_nlerp_unit; expects clk and arst_n in the including scope.
`ifndef QUATERNION_NLERP_UNIT_MACROS_SVH
`define QUATERNION_NLERP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked in the same cycle
`define QNL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Implication checked in the next cycle
`define QNL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define QNL_ASSERT_IMP(lbl, ante, cons, msg)
`define QNL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/qnl_pkg.sv =====
// Shared constants and types for the quaternion blend pipeline.
// No dependencies; used by qnl_isqrt, qnl_div and quaternion_nlerp_unit.
package qnl_pkg;
	localparam int COMP_BITS_DEF = 16;
	localparam int WEIGHT_BITS = 17;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;
	// the largest normalized magnitude lies in [2^29, 2^30)
	localparam int NORM_BITS = 30;
	localparam int SQ_BITS = 62;
	localparam int ROOT_BITS = 31;
	localparam int LANES = 4;

	typedef struct packed {
		logic valid;
		logic zero_len;
	} ctl_t;
endpackage

// ===== rtl/core/qnl_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with payload.
// Depends on qnl_pkg.
module qnl_isqrt #(
	parameter int PAY_W = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ce,
	input  qnl_pkg::ctl_t                   in_ctl,
	input  logic [qnl_pkg::SQ_BITS-1:0]     in_n2,
	input  logic [PAY_W-1:0]                in_pay,
	output qnl_pkg::ctl_t                   out_ctl,
	output logic [qnl_pkg::ROOT_BITS-1:0]   out_root,
	output logic [PAY_W-1:0]                out_pay
);
	localparam int SQ = qnl_pkg::SQ_BITS;
	localparam int RT = qnl_pkg::ROOT_BITS;

	qnl_pkg::ctl_t    ctl_q [1:RT];
	logic [SQ-1:0]    rem_q [1:RT];
	logic [SQ-1:0]    res_q [1:RT];
	logic [PAY_W-1:0] pay_q [1:RT];

	for (genvar s = 0; s < RT; s++) begin : g_it
		localparam logic [SQ-1:0] BIT = SQ'(1) << (2 * (RT - 1 - s));
		qnl_pkg::ctl_t    ctl_c;
		logic [SQ-1:0]    rem_c;
		logic [SQ-1:0]    res_c;
		logic [SQ-1:0]    sum_c;
		logic [PAY_W-1:0] pay_c;
		logic             take;

		if (s == 0) begin : g_first
			assign ctl_c = in_ctl;
			assign rem_c = in_n2;
			assign res_c = '0;
			assign pay_c = in_pay;
		end else begin : g_next
			assign ctl_c = ctl_q[s];
			assign rem_c = rem_q[s];
			assign res_c = res_q[s];
			assign pay_c = pay_q[s];
		end

		// try the next root bit
		assign sum_c = res_c + BIT;
		assign take = rem_c >= sum_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[s+1] <= '0;
			end else if (ce) begin
				ctl_q[s+1] <= ctl_c;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_q[s+1] <= take ? rem_c - sum_c : rem_c;
				res_q[s+1] <= take ? (res_c >> 1) + BIT : res_c >> 1;
				pay_q[s+1] <= pay_c;
			end
		end
	end

	assign out_ctl  = ctl_q[RT];
	assign out_root = res_q[RT][RT-1:0];
	assign out_pay  = pay_q[RT];
endmodule

// ===== rtl/core/qnl_div.sv =====
// Four-lane pipelined restoring divider: rounded magnitude over norm.
// Depends on qnl_pkg.
module qnl_div #(
	parameter int COMP_BITS = qnl_pkg::COMP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ce,
	input  qnl_pkg::ctl_t                   in_ctl,
	input  logic [qnl_pkg::NORM_BITS-1:0]   in_mag [qnl_pkg::LANES],
	input  logic [qnl_pkg::ROOT_BITS-1:0]   in_root,
	input  logic [qnl_pkg::LANES-1:0]       in_neg,
	output qnl_pkg::ctl_t                   out_ctl,
	output logic [COMP_BITS-1:0]            out_q [qnl_pkg::LANES],
	output logic [qnl_pkg::LANES-1:0]       out_neg
);
	localparam int C  = COMP_BITS;
	localparam int L  = qnl_pkg::LANES;
	localparam int RT = qnl_pkg::ROOT_BITS;
	localparam int DW = C + qnl_pkg::NORM_BITS + 1;

	qnl_pkg::ctl_t ctl_q  [0:C];
	logic [RT-1:0] norm_q [0:C];
	logic [L-1:0]  neg_q  [0:C];
	logic [DW-1:0] rem_q  [0:C][L];
	logic [C-1:0]  quo_q  [0:C][L];

	// form mag * 2^(C-1) + norm/2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q[0] <= '0;
		end else if (ce) begin
			ctl_q[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			norm_q[0] <= in_root;
			neg_q[0]  <= in_neg;
			for (int i = 0; i < L; i++) begin
				rem_q[0][i] <= DW'({in_mag[i], {(C-1){1'b0}}}) + DW'(in_root >> 1);
				quo_q[0][i] <= '0;
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar s = 0; s < C; s++) begin : g_bit
		localparam int J = C - 1 - s;
		logic [DW-1:0] den;

		assign den = DW'(norm_q[s]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[s+1] <= '0;
			end else if (ce) begin
				ctl_q[s+1] <= ctl_q[s];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				norm_q[s+1] <= norm_q[s];
				neg_q[s+1]  <= neg_q[s];
				for (int i = 0; i < L; i++) begin
					if (rem_q[s][i] >= den) begin
						rem_q[s+1][i] <= rem_q[s][i] - den;
						quo_q[s+1][i] <= quo_q[s][i] | (C'(1) << J);
					end else begin
						rem_q[s+1][i] <= rem_q[s][i];
						quo_q[s+1][i] <= quo_q[s][i];
					end
				end
			end
		end
	end

	assign out_ctl = ctl_q[C];
	assign out_neg = neg_q[C];
	assign out_q   = quo_q[C];
endmodule

// ===== rtl/core/quaternion_nlerp_unit.sv =====
// Normalized shortest-arc quaternion blend, fully pipelined stream unit.
// Depends on qnl_pkg, qnl_isqrt, qnl_div and quaternion_nlerp_unit_macros.svh.
//
//   channel  dir  fields
//   s_axis   in   a_x a_y a_z a_w b_x b_y b_z b_w blend_weight (tdata)
//   m_axis   out  r_x r_y r_z r_w (tdata), zero_length (tuser)
//
// One transaction in and one out per cycle while the output is not stalled. It has
// nine front stages, 31 root stages (one root bit each), COMP_BITS + 1
// divider stages (one quotient bit each), one saturation stage and the
// output register.
// Reset clears only the valid bits and the control words that carry them. A one-entry skid behind the output
// register absorbs a stall; while it is full the pipeline holds and
// s_axis_tready is low.
`include "quaternion_nlerp_unit_macros.svh"
module quaternion_nlerp_unit #(
	parameter int COMP_BITS = qnl_pkg::COMP_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend_weight, zero pad
	input  logic [((8*COMP_BITS+qnl_pkg::WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// r_x, r_y, r_z, r_w, zero pad
	output logic [((4*COMP_BITS+7)/8)*8-1:0] m_axis_tdata,
	// zero_length
	output logic [0:0] m_axis_tuser
);
	localparam int C   = COMP_BITS;
	localparam int L   = qnl_pkg::LANES;
	localparam int WB  = qnl_pkg::WEIGHT_BITS;
	localparam int NB  = qnl_pkg::NORM_BITS;
	localparam int SQ  = qnl_pkg::SQ_BITS;
	localparam int RW  = C + WB + 1;
	localparam int MW  = RW - 1;
	localparam int DTW = 2 * C + 2;
	localparam int LZW = $clog2(MW + 1);
	localparam int PW  = L + L * NB;
	localparam int OW  = ((4 * C + 7) / 8) * 8;
	localparam logic [C-1:0] LIM_M1 = {1'b0, {(C-1){1'b1}}};

	logic ce;
	logic skid_valid_q;
	logic out_valid_q;

	assign ce = !skid_valid_q;
	assign s_axis_tready = ce;

	// unpack and clamp the weight
	logic signed [C-1:0] a_c [L];
	logic signed [C-1:0] b_c [L];
	logic [WB-1:0] w_in, wb_c, wa_c;

	always_comb begin
		for (int i = 0; i < L; i++) begin
			a_c[i] = s_axis_tdata[i*C +: C];
			b_c[i] = s_axis_tdata[(L+i)*C +: C];
		end
	end
	assign w_in = s_axis_tdata[2*L*C +: WB];
	assign wb_c = (w_in > qnl_pkg::WEIGHT_ONE) ? qnl_pkg::WEIGHT_ONE : w_in;
	assign wa_c = qnl_pkg::WEIGHT_ONE - wb_c;

	// valid bits of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	logic signed [2*C-1:0] dp_s1 [L];
	logic signed [RW-1:0]  pa_s1 [L];
	logic signed [RW-1:0]  pb_s1 [L];
	logic                  neg_s2;
	logic signed [RW-1:0]  pa_s2 [L];
	logic signed [RW-1:0]  pb_s2 [L];
	logic signed [RW-1:0]  r_s3 [L];
	logic [MW-1:0]         mag_s4 [L];
	logic [L-1:0]          sg_s4;
	logic [MW-1:0]         mag_s5 [L];
	logic [MW-1:0]         mx_s5;
	logic [L-1:0]          sg_s5;
	logic [MW-1:0]         mag_s6 [L];
	logic [LZW-1:0]        sh_s6;
	logic [L-1:0]          sg_s6;
	logic                  z_s6;
	logic [NB-1:0]         nm_s7 [L];
	logic [L-1:0]          sg_s7;
	logic                  z_s7;
	logic [2*NB-1:0]       sq_s8 [L];
	logic [NB-1:0]         nm_s8 [L];
	logic [L-1:0]          sg_s8;
	logic                  z_s8;
	logic [SQ-1:0]         n2_s9;
	logic [NB-1:0]         nm_s9 [L];
	logic [L-1:0]          sg_s9;
	logic                  z_s9;

	// exact dot-product sum and largest magnitude
	logic signed [DTW-1:0] dot_c;
	logic [MW-1:0]         mx01_c, mx23_c;
	logic [LZW-1:0]        sh_c;

	assign dot_c = DTW'(dp_s1[0]) + DTW'(dp_s1[1]) + DTW'(dp_s1[2]) + DTW'(dp_s1[3]);
	assign mx01_c = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
	assign mx23_c = (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];

	// position of the leading one, plus one
	always_comb begin
		sh_c = '0;
		for (int k = 0; k < MW; k++) begin
			if (mx_s5[k]) begin
				sh_c = LZW'(k + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < L; i++) begin
				// stage 1: products
				dp_s1[i] <= a_c[i] * b_c[i];
				pa_s1[i] <= a_c[i] * $signed({1'b0, wa_c});
				pb_s1[i] <= b_c[i] * $signed({1'b0, wb_c});
				// stage 2: sign of the dot product
				pa_s2[i] <= pa_s1[i];
				pb_s2[i] <= pb_s1[i];
				// stage 3: blend, flipping b for the short arc
				r_s3[i] <= neg_s2 ? pa_s2[i] - pb_s2[i] : pa_s2[i] + pb_s2[i];
				// stage 4: magnitude and sign
				mag_s4[i] <= r_s3[i][RW-1] ? MW'(-r_s3[i]) : MW'(r_s3[i]);
				sg_s4[i]  <= r_s3[i][RW-1];
				mag_s5[i] <= mag_s4[i];
				mag_s6[i] <= mag_s5[i];
				// stage 7: bring the largest into [2^29, 2^30)
				nm_s7[i] <= NB'({mag_s6[i], {NB{1'b0}}} >> sh_s6);
				// stage 8: squares
				sq_s8[i] <= nm_s7[i] * nm_s7[i];
				nm_s8[i] <= nm_s7[i];
				nm_s9[i] <= nm_s8[i];
			end
			neg_s2 <= dot_c[DTW-1];
			mx_s5  <= (mx01_c > mx23_c) ? mx01_c : mx23_c;
			sg_s5  <= sg_s4;
			sh_s6  <= sh_c;
			z_s6   <= (mx_s5 == '0);
			sg_s6  <= sg_s5;
			sg_s7  <= sg_s6;
			z_s7   <= z_s6;
			sg_s8  <= sg_s7;
			z_s8   <= z_s7;
			// stage 9: sum of squares
			n2_s9  <= SQ'(sq_s8[0]) + SQ'(sq_s8[1]) + SQ'(sq_s8[2]) + SQ'(sq_s8[3]);
			sg_s9  <= sg_s8;
			z_s9   <= z_s8;
		end
	end

	// root of the sum of squares
	qnl_pkg::ctl_t           sq_in_ctl, sq_out_ctl;
	logic [PW-1:0]           sq_in_pay, sq_out_pay;
	logic [qnl_pkg::ROOT_BITS-1:0] root;

	assign sq_in_ctl.valid    = v_s9;
	assign sq_in_ctl.zero_len = z_s9;
	assign sq_in_pay = {sg_s9, nm_s9[3], nm_s9[2], nm_s9[1], nm_s9[0]};

	qnl_isqrt #(
		.PAY_W(PW)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_ctl  (sq_in_ctl),
		.in_n2   (n2_s9),
		.in_pay  (sq_in_pay),
		.out_ctl (sq_out_ctl),
		.out_root(root),
		.out_pay (sq_out_pay)
	);

	// divide each magnitude by the norm
	logic [NB-1:0] dv_mag [L];
	qnl_pkg::ctl_t dv_ctl;
	logic [C-1:0]  dv_q [L];
	logic [L-1:0]  dv_neg;

	always_comb begin
		for (int i = 0; i < L; i++) begin
			dv_mag[i] = sq_out_pay[i*NB +: NB];
		end
	end

	qnl_div #(
		.COMP_BITS(C)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ce     (ce),
		.in_ctl (sq_out_ctl),
		.in_mag (dv_mag),
		.in_root(root),
		.in_neg (sq_out_pay[PW-1 -: L]),
		.out_ctl(dv_ctl),
		.out_q  (dv_q),
		.out_neg(dv_neg)
	);

	// sign, saturate, zero-length override
	logic         v_s10;
	logic [C-1:0] r_s10 [L];
	logic         z_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (ce) begin
			v_s10 <= dv_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			z_s10 <= dv_ctl.zero_len;
			for (int i = 0; i < L; i++) begin
				if (dv_ctl.zero_len) begin
					r_s10[i] <= '0;
				end else if (dv_neg[i]) begin
					r_s10[i] <= (~dv_q[i]) + C'(1);
				end else begin
					r_s10[i] <= (dv_q[i] > LIM_M1) ? LIM_M1 : dv_q[i];
				end
			end
		end
	end

	// output register with one-entry skid
	logic [4*C-1:0] out_data_q, skid_data_q;
	logic           out_zero_q, skid_zero_q;
	logic [4*C-1:0] tail_data;

	assign tail_data = {r_s10[3], r_s10[2], r_s10[1], r_s10[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (v_s10) begin
			if (!out_valid_q || m_axis_tready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
				out_zero_q <= skid_zero_q;
			end
		end else if (v_s10) begin
			if (!out_valid_q || m_axis_tready) begin
				out_data_q <= tail_data;
				out_zero_q <= z_s10;
			end else begin
				skid_data_q <= tail_data;
				skid_zero_q <= z_s10;
			end
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = OW'(out_data_q);
	assign m_axis_tuser[0] = out_zero_q;

	`QNL_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
	`QNL_ASSERT_NXT(a_skid_fill, !skid_valid_q && v_s10 && out_valid_q && !m_axis_tready, skid_valid_q, "result lost on stall")
	`QNL_ASSERT_NXT(a_skid_hold, skid_valid_q && !m_axis_tready, skid_valid_q && !s_axis_tready, "skid dropped while stalled")
	`QNL_ASSERT_IMP(a_zero_result, out_valid_q && out_zero_q, out_data_q == '0, "zero-length result not zero")
endmodule

// ===== sim/quaternion_nlerp_unit_tb.sv =====
// Testbench for quaternion_nlerp_unit: shortest-arc normalized quaternion blend.
// Depends on qnl_pkg and the RTL; predicts each result in-bench and checks in order.
module quaternion_nlerp_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = qnl_pkg::COMP_BITS_DEF;
	localparam int IN_W = ((8*CB+qnl_pkg::WEIGHT_BITS+7)/8)*8;
	localparam int OUT_W = ((4*CB+7)/8)*8;
	localparam int LATENCY = CB + 43;

	typedef struct packed {
		logic [CB-1:0] rx, ry, rz, rw;
		logic zl;
	} blend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	blend_t blend_q[$];
	int errors = 0;
	bit hold_off = 1'b0;

	quaternion_nlerp_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	// Compute the expected normalized blend of one input word
	function automatic blend_t predict_blend(logic [IN_W-1:0] d);
		longint a[4], b[4], r[4], dot;
		longint unsigned mag[4], m, n2, norm, half, q, lim, w, res, bit_v, n;
		int rsh, lsh;
		logic [CB-1:0] o[4];
		blend_t e;
		dot = 0; m = 0; n2 = 0; rsh = 0; lsh = 0;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(d[i*CB +: CB]));
			b[i] = longint'($signed(d[(4+i)*CB +: CB]));
			dot += a[i] * b[i];
		end
		w = 64'(d[8*CB +: 17]);
		if (w > 65536) w = 65536;
		for (int i = 0; i < 4; i++) begin
			r[i] = a[i] * longint'(65536 - w) + (dot < 0 ? -b[i] : b[i]) * longint'(w);
			mag[i] = r[i] < 0 ? -r[i] : r[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			e = '0;
			e.zl = 1'b1;
			return e;
		end
		while (m >= (64'd1 << 30)) begin m >>= 1; rsh++; end
		while (m < (64'd1 << 29)) begin m <<= 1; lsh++; end
		for (int i = 0; i < 4; i++) begin
			mag[i] = (mag[i] >> rsh) << lsh;
			n2 += mag[i] * mag[i];
		end
		// integer square root, bit by bit
		n = n2; res = 0; bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		norm = res;
		half = norm >> 1;
		lim = 64'd1 << (CB-1);
		for (int i = 0; i < 4; i++) begin
			q = ((mag[i] << (CB-1)) + half) / norm;
			if (r[i] < 0) begin
				if (q > lim) q = lim;
				o[i] = CB'(-q);
			end else begin
				if (q > lim - 1) q = lim - 1;
				o[i] = CB'(q);
			end
		end
		e.rx = o[0]; e.ry = o[1]; e.rz = o[2]; e.rw = o[3]; e.zl = 1'b0;
		return e;
	endfunction

	// Send one transaction after a random gap, queue its expectation
	task automatic send_blend(logic [CB-1:0] ax, ay, az, aw, bx, by, bz, bw,
			logic [16:0] wt);
		logic [IN_W-1:0] d;
		int gap;
		d = '0;
		d[8*CB-1:0] = {bw, bz, by, bx, aw, az, ay, ax};
		d[8*CB +: 17] = wt;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// drop valid only while idling between transactions
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		blend_q = {blend_q, predict_blend(d)};
	endtask

	task automatic send_random(int kind);
		logic [CB-1:0] c[8];
		logic [16:0] wt;
		for (int i = 0; i < 8; i++) begin
			c[i] = CB'($urandom);
			if (kind == 1) c[i] = $signed(c[i]) >>> $urandom_range(0, 14);
		end
		case ($urandom_range(0, 5))
			0: wt = 17'(17'h10000 + $urandom_range(0, 65535));
			1: wt = $urandom_range(0, 1) ? 17'h0 : 17'h10000;
			default: wt = 17'($urandom_range(0, 65536));
		endcase
		if (kind == 2) begin
			// opposite quaternions: b equals -a, the short-arc flip turns b back into a
			for (int i = 0; i < 4; i++) c[4+i] = -c[i];
			if ($urandom_range(0, 1)) wt = 17'h8000;
		end
		send_blend(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], wt);
	endtask

	// Drain: release the input, wait until all expectations are met, then let the pipeline run empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (blend_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic test_directed();
		localparam logic [CB-1:0] MX = 16'h7FFF, MN = 16'h8000, Z = 16'h0;
		send_blend(MX, Z, Z, Z, MX, Z, Z, Z, 17'h0);
		send_blend(MX, Z, Z, Z, MX, Z, Z, Z, 17'h10000);
		send_blend(MN, Z, Z, Z, MN, Z, Z, Z, 17'h8000);
		send_blend(MN, MN, MN, MN, MN, MN, MN, MN, 17'h1FFFF);
		send_blend(MX, MX, MX, MX, MX, MX, MX, MX, 17'h10001);
		send_blend(Z, Z, Z, Z, Z, Z, Z, Z, 17'h4000);
		send_blend(MX, Z, Z, Z, MN, Z, Z, Z, 17'h8000);
		send_blend(16'h1, Z, Z, Z, Z, Z, Z, 16'h1, 17'h10000);
		send_blend(16'h1, Z, Z, Z, Z, Z, Z, Z, 17'h0);
		send_blend(Z, Z, MX, Z, Z, MN, Z, Z, 17'h8000);
		send_blend(MX, Z, Z, Z, Z, MX, Z, Z, 17'h0FFFF);
		send_blend(16'h5A82, 16'h5A82, Z, Z, 16'hA57E, 16'h5A82, Z, Z, 17'h1);
		send_blend(MN, Z, Z, Z, Z, Z, Z, 16'hFFFF, 17'h10000);
		send_blend(16'hFFFF, 16'h1, Z, Z, 16'h1, 16'hFFFF, Z, Z, 17'h8000);
		wait_drained();
	endtask

	task automatic test_random();
		for (int n = 0; n < 770; n++) send_random(n % 10 == 0 ? 2 : (n % 3 == 0 ? 1 : 0));
		wait_drained();
	endtask

	// Hold the output off long enough that the pipeline fills and stalls input
	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int n = 0; n < 120; n++) send_random(0);
		hold_off = 1'b0;
		wait_drained();
	endtask

	// Receiver ready: random stalls, plus a long counted hold-off
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				stall = 0;
				while (stall < 300) begin @(posedge clk); stall++; end
				m_axis_tready <= 1'b1;
				while (hold_off) @(posedge clk);
			end else begin
				stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
				m_axis_tready <= (stall == 0);
			end
		end
	end

	// Compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		blend_t got, exp_b;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[4*CB-1:0], m_axis_tuser[0]};
			got = {m_axis_tdata[4*CB-1:3*CB], m_axis_tdata[3*CB-1:2*CB],
				m_axis_tdata[2*CB-1:CB], m_axis_tdata[CB-1:0], m_axis_tuser[0]};
			got = {got.rw, got.rz, got.ry, got.rx, got.zl};
			if (blend_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_b = blend_q.pop_front();
				if (got.rx !== exp_b.rx) begin
					$display("%0t: r_x expected %h actual %h", $time, exp_b.rx, got.rx);
					errors++;
				end
				if (got.ry !== exp_b.ry) begin
					$display("%0t: r_y expected %h actual %h", $time, exp_b.ry, got.ry);
					errors++;
				end
				if (got.rz !== exp_b.rz) begin
					$display("%0t: r_z expected %h actual %h", $time, exp_b.rz, got.rz);
					errors++;
				end
				if (got.rw !== exp_b.rw) begin
					$display("%0t: r_w expected %h actual %h", $time, exp_b.rw, got.rw);
					errors++;
				end
				if (got.zl !== exp_b.zl) begin
					$display("%0t: zero_length expected %b actual %b", $time,
						exp_b.zl, got.zl);
					errors++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("quaternion_nlerp_unit_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		if (errors == 0 && blend_q.size() == 0) begin
			$display("quaternion_nlerp_unit_tb: PASS");
		end else begin
			$display("quaternion_nlerp_unit_tb: FAIL");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/qnl_pkg.sv
rtl/core/qnl_isqrt.sv
rtl/core/qnl_div.sv
rtl/core/quaternion_nlerp_unit.sv
sim/quaternion_nlerp_unit_tb.sv
